FILE: hdl/multichannel_biquad_filter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel biquad filter
// Shorthand for clocked implication checks with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_BIQUAD_FILTER_ASSERT_SVH
`define MULTICHANNEL_BIQUAD_FILTER_ASSERT_SVH

// Same-cycle implication.
`define MBQ_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("biquad filter check failed");

// Next-cycle implication.
`define MBQ_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("biquad filter check failed");

`endif

FILE: hdl/mbq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad filter package
// Widths, types and register codes shared by the biquad filter modules.
// ----------------------------------------------------------------------------
package mbq_pkg;

	localparam int CHANNELS_DEF = 2;
	localparam int CH_W         = 1;
	localparam int SAMP_W       = 24;
	localparam int COEF_W       = 28;
	localparam int PROD_W       = SAMP_W + COEF_W;
	localparam int ACC_W        = PROD_W + 3;
	localparam int FRAC_SHIFT   = 24;
	localparam int YF_W         = ACC_W - FRAC_SHIFT;
	localparam int CFG_IDX_W    = 3;
	localparam int HIST_DEPTH   = 2 ** CH_W;

	typedef logic signed [SAMP_W-1:0] samp_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	localparam samp_t SAMP_MAX   = {1'b0, {(SAMP_W-1){1'b1}}};
	localparam samp_t SAMP_MIN   = {1'b1, {(SAMP_W-1){1'b0}}};
	localparam coef_t FF0_RESET  = coef_t'(32'sd16777216);
	localparam acc_t  ROUND_HALF = acc_t'(1) <<< (FRAC_SHIFT - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FF0 = 3'd0,
		REG_FF1 = 3'd1,
		REG_FF2 = 3'd2,
		REG_FB1 = 3'd3,
		REG_FB2 = 3'd4
	} reg_idx_t;

	typedef struct packed {
		coef_t f0;
		coef_t f1;
		coef_t f2;
		coef_t g1;
		coef_t g2;
	} coef_set_t;

	// One history word per channel.
	typedef struct packed {
		samp_t x1;
		samp_t x2;
		samp_t y1;
		samp_t y2;
	} hist_t;

	typedef struct packed {
		logic            we;
		logic [CH_W-1:0] addr;
		hist_t           data;
	} hist_wr_t;

	// Channel tag of an item in flight; wr marks a channel that owns history.
	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            wr;
	} tag_t;

	typedef struct packed {
		logic ld1;
		logic ld2;
		logic ld3;
		logic ld_out;
	} stage_en_t;

endpackage

FILE: hdl/mbq_coef_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad coefficient registers
// Holds the five Q3.24 coefficients written through the configuration port.
// ----------------------------------------------------------------------------
module mbq_coef_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [mbq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  mbq_pkg::coef_t                 cfg_data,
	output logic                           cfg_ready,
	output mbq_pkg::coef_set_t             coef
);
	import mbq_pkg::*;

	coef_set_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.f0 <= FF0_RESET;
			coef_q.f1 <= '0;
			coef_q.f2 <= '0;
			coef_q.g1 <= '0;
			coef_q.g2 <= '0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_FF0: coef_q.f0 <= cfg_data;
				REG_FF1: coef_q.f1 <= cfg_data;
				REG_FF2: coef_q.f2 <= cfg_data;
				REG_FB1: coef_q.g1 <= cfg_data;
				REG_FB2: coef_q.g2 <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign coef      = coef_q;

endmodule

FILE: hdl/mbq_hist_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad history memory
// Per-channel past inputs and outputs, registered read, write-first
// forwarding, and valid bits so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module mbq_hist_mem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [mbq_pkg::CH_W-1:0]  rd_addr,
	output mbq_pkg::hist_t            rd_data,
	input  mbq_pkg::hist_wr_t         wr
);
	import mbq_pkg::*;

	hist_t                 mem [HIST_DEPTH];
	hist_t                 rd_q;
	logic                  rd_vld_q;
	logic [HIST_DEPTH-1:0] vld_q;
	logic                  fwd;

	assign fwd = wr.we && (wr.addr == rd_addr);

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// A read that meets a write to the same entry returns the new word.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= fwd ? wr.data : mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.we) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr] || fwd;
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

FILE: hdl/mbq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad arithmetic pipeline
// Products, partial sums, rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module mbq_datapath (
	input  logic                      clk,
	input  mbq_pkg::stage_en_t        en,
	input  mbq_pkg::coef_set_t        coef,
	input  logic [mbq_pkg::CH_W-1:0]  channel,
	input  logic                      in_range,
	input  mbq_pkg::samp_t            sample_in,
	input  mbq_pkg::hist_t            hist,
	output mbq_pkg::tag_t             tag_s1,
	output mbq_pkg::tag_t             tag_s2,
	output mbq_pkg::tag_t             tag_s3,
	output mbq_pkg::hist_t            wr_data,
	output logic [mbq_pkg::CH_W-1:0]  channel_out,
	output mbq_pkg::samp_t            sample_out,
	output logic                      clipped
);
	import mbq_pkg::*;

	samp_t             x_s1;
	tag_t              tag_s1_q;
	prod_t             p0_s2, p1_s2, p2_s2, p3_s2, p4_s2;
	samp_t             x_s2, x1_s2, y1_s2;
	tag_t              tag_s2_q;
	acc_t              sum_a_s3, sum_b_s3;
	samp_t             x_s3, x1_s3, y1_s3;
	tag_t              tag_s3_q;
	prod_t             prod0, prod1, prod2, prod3, prod4;
	acc_t              acc;
	logic signed [YF_W-1:0] y_full;
	logic              over, under;
	samp_t             y_sat;
	logic [CH_W-1:0]   channel_q;
	samp_t             sample_q;
	logic              clipped_q;

	always_ff @(posedge clk) begin
		if (en.ld1) begin
			x_s1        <= sample_in;
			tag_s1_q.ch <= channel;
			tag_s1_q.wr <= in_range;
		end
	end

	assign prod0 = x_s1 * coef.f0;
	assign prod1 = hist.x1 * coef.f1;
	assign prod2 = hist.x2 * coef.f2;
	assign prod3 = hist.y1 * coef.g1;
	assign prod4 = hist.y2 * coef.g2;

	always_ff @(posedge clk) begin
		if (en.ld2) begin
			p0_s2    <= prod0;
			p1_s2    <= prod1;
			p2_s2    <= prod2;
			p3_s2    <= prod3;
			p4_s2    <= prod4;
			x_s2     <= x_s1;
			x1_s2    <= hist.x1;
			y1_s2    <= hist.y1;
			tag_s2_q <= tag_s1_q;
		end
	end

	// The rounding half is folded into the feedforward sum.
	always_ff @(posedge clk) begin
		if (en.ld3) begin
			sum_a_s3 <= acc_t'(p0_s2) + acc_t'(p1_s2) + acc_t'(p2_s2) + ROUND_HALF;
			sum_b_s3 <= acc_t'(p3_s2) + acc_t'(p4_s2);
			x_s3     <= x_s2;
			x1_s3    <= x1_s2;
			y1_s3    <= y1_s2;
			tag_s3_q <= tag_s2_q;
		end
	end

	always_comb begin
		acc    = sum_a_s3 - sum_b_s3;
		y_full = acc[ACC_W-1:FRAC_SHIFT];
		over   = y_full > YF_W'(SAMP_MAX);
		under  = y_full < YF_W'(SAMP_MIN);
		if (over) begin
			y_sat = SAMP_MAX;
		end else if (under) begin
			y_sat = SAMP_MIN;
		end else begin
			y_sat = y_full[SAMP_W-1:0];
		end
	end

	assign wr_data.x1 = x_s3;
	assign wr_data.x2 = x1_s3;
	assign wr_data.y1 = y_sat;
	assign wr_data.y2 = y1_s3;

	always_ff @(posedge clk) begin
		if (en.ld_out) begin
			channel_q <= tag_s3_q.ch;
			sample_q  <= y_sat;
			clipped_q <= over || under;
		end
	end

	assign tag_s1      = tag_s1_q;
	assign tag_s2      = tag_s2_q;
	assign tag_s3      = tag_s3_q;
	assign channel_out = channel_q;
	assign sample_out  = sample_q;
	assign clipped     = clipped_q;

endmodule

FILE: hdl/multichannel_biquad_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multichannel biquad filter
// Direct form I biquad with per-channel history held in a small memory.
//
//   port group  direction  handshake                 payload
//   sample      in         sample_valid/sample_stall channel, sample_in
//   result      out        result_valid/result_stall channel_out, sample_out, clipped
//   cfg         in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// Pipeline steps: history read, multiply, partial sums, round, saturate and
// write back into the output register. One request per cycle while channels
// differ and results are not stalled; a request waits while an earlier one on
// its channel is in the read-multiply-sum-write loop through the history
// memory. Reset clears the coefficients to unity gain and marks all history
// empty. A stalled result holds the pipeline only as far back as it is full.
// ----------------------------------------------------------------------------
module multichannel_biquad_filter #(
	parameter int CHANNELS = mbq_pkg::CHANNELS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  logic [mbq_pkg::CH_W-1:0]       channel,
	input  mbq_pkg::samp_t                 sample_in,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [mbq_pkg::CH_W-1:0]       channel_out,
	output mbq_pkg::samp_t                 sample_out,
	output logic                           clipped,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mbq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  mbq_pkg::coef_t                 cfg_data
);
	import mbq_pkg::*;

	coef_set_t coef;
	hist_t     hist;
	hist_t     wr_data;
	hist_wr_t  wr;
	stage_en_t en;
	tag_t      tag_s1, tag_s2, tag_s3;
	logic      s1_v_q, s2_v_q, s3_v_q, out_v_q;
	logic      in_range, hazard, accept;

	assign in_range = int'(channel) < CHANNELS;

	always_comb begin
		en.ld_out = !out_v_q || !result_stall;
		en.ld3    = !s3_v_q || en.ld_out;
		en.ld2    = !s2_v_q || en.ld3;
		en.ld1    = !s1_v_q || en.ld2;
	end

	// A request waits while an earlier one on its channel has not yet written
	// its history back; the write-back cycle itself is covered by forwarding.
	assign hazard = in_range && (
		(s1_v_q && tag_s1.wr && tag_s1.ch == channel) ||
		(s2_v_q && tag_s2.wr && tag_s2.ch == channel) ||
		(s3_v_q && tag_s3.wr && tag_s3.ch == channel && !en.ld_out));

	assign accept       = sample_valid && en.ld1 && !hazard;
	assign sample_stall = !en.ld1 || hazard;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			s3_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en.ld1) begin
				s1_v_q <= accept;
			end
			if (en.ld2) begin
				s2_v_q <= s1_v_q;
			end
			if (en.ld3) begin
				s3_v_q <= s2_v_q;
			end
			if (en.ld_out) begin
				out_v_q <= s3_v_q;
			end
		end
	end

	assign wr.we   = s3_v_q && en.ld_out && tag_s3.wr;
	assign wr.addr = tag_s3.ch;
	assign wr.data = wr_data;

	mbq_coef_regs u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.coef      (coef)
	);

	mbq_hist_mem u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (en.ld1),
		.rd_addr (channel),
		.rd_data (hist),
		.wr      (wr)
	);

	mbq_datapath u_dp (
		.clk         (clk),
		.en          (en),
		.coef        (coef),
		.channel     (channel),
		.in_range    (in_range),
		.sample_in   (sample_in),
		.hist        (hist),
		.tag_s1      (tag_s1),
		.tag_s2      (tag_s2),
		.tag_s3      (tag_s3),
		.wr_data     (wr_data),
		.channel_out (channel_out),
		.sample_out  (sample_out),
		.clipped     (clipped)
	);

	assign result_valid = out_v_q;

endmodule

FILE: hdl/mbq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad filter port checker
// Watches the top-level ports for request bookkeeping and result sanity.
// ----------------------------------------------------------------------------
`include "multichannel_biquad_filter_assert.svh"

module mbq_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      sample_valid,
	input  logic                      sample_stall,
	input  logic                      result_valid,
	input  logic                      result_stall,
	input  logic [mbq_pkg::CH_W-1:0]  channel_out,
	input  mbq_pkg::samp_t            sample_out,
	input  logic                      clipped
);
	import mbq_pkg::*;

	logic [2:0] count_q;
	logic       in_acc, out_acc;

	assign in_acc  = sample_valid && !sample_stall;
	assign out_acc = result_valid && !result_stall;

	// Requests taken but whose results are not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q + 3'(in_acc) - 3'(out_acc);
		end
	end

	`MBQ_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid && $stable(sample_out) && $stable(channel_out) && $stable(clipped))
	`MBQ_ASSERT_IMPL(a_in_flight_bound, 1'b1, count_q <= 3'd4)
	`MBQ_ASSERT_IMPL(a_no_orphan_result, result_valid, count_q != 3'd0)
	`MBQ_ASSERT_IMPL(a_empty_takes_request, count_q == 3'd0, !sample_stall)
	`MBQ_ASSERT_IMPL(a_clip_at_rail, result_valid && clipped, sample_out == SAMP_MAX || sample_out == SAMP_MIN)

endmodule

bind multichannel_biquad_filter mbq_checker u_mbq_checker (.*);

FILE: sim/tb_multichannel_biquad_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the multichannel biquad filter
// Drives tagged samples through the filter and checks every filtered sample
// against a fixed-point direct form I model that keeps its own coefficients
// and per-channel history. Directed cases cover unity gain after reset,
// rounding, saturation in both directions with saturated values fed back,
// and writes to unused register indexes. Random phases follow with wild, tame
// and extreme coefficients; after the first, random idling on a side or both.
// ----------------------------------------------------------------------------
module tb_multichannel_biquad_filter;
	import mbq_pkg::*;

	localparam int     CLK_PERIOD    = 10;
	localparam int     RESET_CYCLES  = 12;
	localparam int     PIPE_LATENCY  = 4;
	localparam int     STALL_LIMIT   = 5000;
	localparam int     FILT_CHANNELS = CHANNELS_DEF;
	localparam int     NUM_COEFS     = int'(REG_FB2) + 1;
	localparam int     RAND_PHASES   = 6;
	localparam int     PHASE_ITEMS   = 75;
	localparam int     TAME_FF_SPAN  = 1 << 25;
	localparam int     TAME_FB_SPAN  = 1 << 23;
	localparam longint ROUND_BIAS    = longint'(1) << (FRAC_SHIFT - 1);
	localparam coef_t  COEF_MAX      = {1'b0, {(COEF_W-1){1'b1}}};
	localparam coef_t  COEF_MIN      = {1'b1, {(COEF_W-1){1'b0}}};
	localparam coef_t  COEF_ZERO     = '0;
	localparam coef_t  COEF_HALF     = coef_t'(1) <<< (FRAC_SHIFT - 1);

	typedef enum int {WILD_FILTER, TAME_FILTER, EXTREME_FILTER} filter_kind_t;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		samp_t           y;
		logic            clip;
	} filt_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 sample_valid;
	logic                 sample_stall;
	logic [CH_W-1:0]      channel;
	samp_t                sample_in;
	logic                 result_valid;
	logic                 result_stall;
	logic [CH_W-1:0]      channel_out;
	samp_t                sample_out;
	logic                 clipped;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	coef_t                cfg_data;

	// Model state: coefficients and per-channel history.
	coef_t coef_reg [NUM_COEFS];
	samp_t in1_hist [FILT_CHANNELS];
	samp_t in2_hist [FILT_CHANNELS];
	samp_t out1_hist [FILT_CHANNELS];
	samp_t out2_hist [FILT_CHANNELS];

	filt_result_t pending_filtered[$];
	int           mismatch_count = 0;
	bit           sender_paced   = 1'b0;
	bit           receiver_paced = 1'b0;

	multichannel_biquad_filter #(
		.CHANNELS(FILT_CHANNELS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.channel      (channel),
		.sample_in    (sample_in),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.channel_out  (channel_out),
		.sample_out   (sample_out),
		.clipped      (clipped),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Filters one sample the way the block should and advances the history.
	function automatic filt_result_t filter_step(input logic [CH_W-1:0] ch, input samp_t x);
		filt_result_t r;
		samp_t        x1, x2, y1, y2;
		longint       acc, y;
		bit           owns_history;
		owns_history = int'(ch) < FILT_CHANNELS;
		x1 = '0;
		x2 = '0;
		y1 = '0;
		y2 = '0;
		if (owns_history) begin
			x1 = in1_hist[ch];
			x2 = in2_hist[ch];
			y1 = out1_hist[ch];
			y2 = out2_hist[ch];
		end
		acc = longint'(coef_reg[REG_FF0]) * longint'(x)
			+ longint'(coef_reg[REG_FF1]) * longint'(x1)
			+ longint'(coef_reg[REG_FF2]) * longint'(x2)
			- longint'(coef_reg[REG_FB1]) * longint'(y1)
			- longint'(coef_reg[REG_FB2]) * longint'(y2);
		// Arithmetic shift floors, so adding half rounds ties upward.
		y = (acc + ROUND_BIAS) >>> FRAC_SHIFT;
		r.ch = ch;
		r.clip = 1'b0;
		if (y > longint'(SAMP_MAX)) begin
			y = longint'(SAMP_MAX);
			r.clip = 1'b1;
		end else if (y < longint'(SAMP_MIN)) begin
			y = longint'(SAMP_MIN);
			r.clip = 1'b1;
		end
		r.y = samp_t'(y);
		if (owns_history) begin
			in2_hist[ch] = x1;
			in1_hist[ch] = x;
			out2_hist[ch] = y1;
			out1_hist[ch] = r.y;
		end
		return r;
	endfunction

	// Mostly short gaps, a few long ones.
	function automatic int pick_gap(input bit paced);
		int roll;
		if (!paced)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic samp_t rand_sample();
		case ($urandom_range(0, 9))
			0: return SAMP_MAX;
			1: return SAMP_MIN;
			2: return samp_t'(int'($urandom_range(0, 512)) - 256);
			default: return samp_t'($urandom);
		endcase
	endfunction

	function automatic coef_t rand_coef(input filter_kind_t kind, input bit feedback);
		int span;
		case (kind)
			TAME_FILTER: begin
				span = feedback ? TAME_FB_SPAN : TAME_FF_SPAN;
				return coef_t'(int'($urandom_range(0, 2 * span)) - span);
			end
			EXTREME_FILTER: begin
				case ($urandom_range(0, 3))
					0: return COEF_MAX;
					1: return COEF_MIN;
					2: return COEF_ZERO;
					default: return coef_t'($urandom);
				endcase
			end
			default: return coef_t'($urandom);
		endcase
	endfunction

	task automatic send_sample(input logic [CH_W-1:0] ch, input samp_t x);
		int gap;
		gap = pick_gap(sender_paced);
		@(negedge clk);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		channel <= ch;
		sample_in <= x;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		pending_filtered.push_back(filter_step(ch, x));
	endtask

	// Waits until every filtered sample is back and the pipeline has emptied.
	task automatic wait_idle();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending_filtered.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input coef_t value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx <= REG_FB2)
			coef_reg[idx] = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_filter(input coef_set_t s);
		wait_idle();
		write_coef(REG_FF0, s.f0);
		write_coef(REG_FF1, s.f1);
		write_coef(REG_FF2, s.f2);
		write_coef(REG_FB1, s.g1);
		write_coef(REG_FB2, s.g2);
	endtask

	// Reset coefficients give unity gain, so samples pass through unchanged.
	task automatic test_unity_gain();
		send_sample(1'b0, SAMP_MAX);
		send_sample(1'b1, SAMP_MIN);
		send_sample(1'b0, samp_t'(0));
		send_sample(1'b1, samp_t'(-1));
		send_sample(1'b0, samp_t'(1));
	endtask

	// With a gain of one half, odd samples land exactly on a tie.
	task automatic test_rounding();
		load_filter({COEF_HALF, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO});
		send_sample(1'b1, samp_t'(1));
		send_sample(1'b0, samp_t'(-1));
		send_sample(1'b1, samp_t'(3));
		send_sample(1'b0, samp_t'(-3));
	endtask

	// Full-scale coefficients clip both ways; clipped outputs feed back.
	task automatic test_saturation();
		load_filter({COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX});
		send_sample(1'b0, SAMP_MAX);
		send_sample(1'b0, SAMP_MAX);
		send_sample(1'b1, SAMP_MIN);
		load_filter({COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN});
		send_sample(1'b0, SAMP_MIN);
		send_sample(1'b1, SAMP_MAX);
		send_sample(1'b0, SAMP_MIN);
	endtask

	// Indexes past the last coefficient must leave the filter untouched.
	task automatic test_unused_index();
		wait_idle();
		for (int idx = int'(REG_FB2) + 1; idx < (1 << CFG_IDX_W); idx++)
			write_coef(CFG_IDX_W'(idx), coef_t'($urandom));
		send_sample(1'b0, rand_sample());
		send_sample(1'b1, rand_sample());
		send_sample(1'b0, rand_sample());
	endtask

	task automatic test_random_filters();
		filter_kind_t    kind;
		logic [CH_W-1:0] ch;
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			kind = filter_kind_t'(phase % 3);
			load_filter({rand_coef(kind, 1'b0), rand_coef(kind, 1'b0), rand_coef(kind, 1'b0),
				rand_coef(kind, 1'b1), rand_coef(kind, 1'b1)});
			sender_paced = phase >= 2;
			receiver_paced = phase == 1 || phase >= 3;
			ch = CH_W'($urandom);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Runs on one channel exercise the history turnaround.
				if ($urandom_range(0, 9) < 4)
					ch = CH_W'($urandom);
				send_sample(ch, rand_sample());
			end
		end
	endtask

	// Result side: random stall windows.
	initial begin
		int hold;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (!receiver_paced) begin
				result_stall <= 1'b0;
			end else begin
				result_stall <= ($urandom_range(0, 2) == 0);
				hold = pick_gap(1'b1);
			end
		end
	end

	always @(posedge clk) begin
		filt_result_t got, want;
		if (arst_n && result_valid && !result_stall) begin
			got = {channel_out, sample_out, clipped};
			if (pending_filtered.size() == 0) begin
				$display("%0t: unexpected result: got ch %0d sample %0d clip %0b",
					$time, got.ch, got.y, got.clip);
				mismatch_count++;
			end else begin
				want = pending_filtered.pop_front();
				if (got !== want) begin
					$display("%0t: expected ch %0d sample %0d clip %0b, got ch %0d sample %0d clip %0b",
						$time, want.ch, want.y, want.clip, got.ch, got.y, got.clip);
					mismatch_count++;
				end
			end
		end
	end

	// Ends the run when no request moves on any channel for too long.
	always @(posedge clk) begin
		int quiet;
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("%0t: timeout with %0d results outstanding", $time,
					pending_filtered.size());
				$display("multichannel_biquad_filter: mismatch");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		sample_valid = 1'b0;
		channel = '0;
		sample_in = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		coef_reg[REG_FF0] = FF0_RESET;
		for (int i = int'(REG_FF1); i < NUM_COEFS; i++)
			coef_reg[CFG_IDX_W'(i)] = COEF_ZERO;
		for (int c = 0; c < FILT_CHANNELS; c++) begin
			in1_hist[CH_W'(c)] = '0;
			in2_hist[CH_W'(c)] = '0;
			out1_hist[CH_W'(c)] = '0;
			out2_hist[CH_W'(c)] = '0;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_unity_gain();
		test_rounding();
		test_saturation();
		test_unused_index();
		test_random_filters();
		wait_idle();

		if (mismatch_count == 0)
			$display("multichannel_biquad_filter: match");
		else
			$display("multichannel_biquad_filter: mismatch");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hdl
hdl/mbq_pkg.sv
hdl/mbq_coef_regs.sv
hdl/mbq_hist_mem.sv
hdl/mbq_datapath.sv
hdl/multichannel_biquad_filter.sv
hdl/mbq_checker.sv
sim/tb_multichannel_biquad_filter.sv
